// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the timer bank RTL (tmb_ctrl).
// Both macros expect signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define TMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen on a clock edge outside reset.
`define TMB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/tmb_pkg.sv =====
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types and codes of the periodic timer bank: request and result
// payloads, operation and life state codes, count unit modes.
// ----------------------------------------------------------------------------
`default_nettype none

package tmb_pkg;

  // operation codes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_INIT    = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_DESTROY = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  // slot life states
  localparam logic [2:0] LIFE_UNUSED    = 3'd0;
  localparam logic [2:0] LIFE_CREATED   = 3'd1;
  localparam logic [2:0] LIFE_STARTED   = 3'd2;
  localparam logic [2:0] LIFE_STOPPED   = 3'd3;
  localparam logic [2:0] LIFE_DESTROYED = 3'd4;

  // result kinds
  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  slot;
    logic [31:0] first_delay;
    logic [31:0] period;
    logic        hard_type;
  } tmb_in_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  which_slot;
    logic [2:0]  life_state;
    logic [31:0] info_delay;
    logic [31:0] info_period;
    logic        info_hard;
    logic        last;
  } tmb_out_t;

  // count unit: load a start value, or step a running count
  typedef enum logic {
    CU_LOAD,
    CU_STEP
  } tmb_cu_mode_t;

  // write enables into the count store
  typedef struct packed {
    logic rem_we;
    logic cfg_we;
  } tmb_st_we_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmb_count_unit.sv =====
// ----------------------------------------------------------------------------
// tmb_count_unit
// Shared count arithmetic: start value select (delay, else period) and the
// per-tick decrement with expiry detect and reload.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_count_unit #(
  parameter int COUNT_BITS = 32
) (
  input  tmb_pkg::tmb_cu_mode_t  mode,
  input  logic [COUNT_BITS-1:0]  a,
  input  logic [COUNT_BITS-1:0]  b,
  output logic [COUNT_BITS-1:0]  res,
  output logic                   fire
);
  import tmb_pkg::*;

  logic a_zero;

  assign a_zero = (a == '0);

  always_comb begin
    fire = 1'b0;
    res  = a;
    unique case (mode)
      CU_LOAD: begin
        res = a_zero ? b : a;
      end
      CU_STEP: begin
        // expires when already zero or when this decrement reaches zero
        fire = a_zero || (a == COUNT_BITS'(1));
        res  = fire ? b : (a - COUNT_BITS'(1));
      end
      default: begin
        res = a;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tmb_store.sv =====
// ----------------------------------------------------------------------------
// tmb_store
// Per-slot count, delay and period storage. One address per cycle, read
// data registered; entries read as zero until the slot is first set up.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_store #(
  parameter int  SLOTS      = 8,
  parameter int  COUNT_BITS = 32,
  localparam int SW         = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SW-1:0]           addr,
  input  tmb_pkg::tmb_st_we_t     we,
  input  logic [COUNT_BITS-1:0]   wr_rem,
  input  logic [COUNT_BITS-1:0]   wr_delay,
  input  logic [COUNT_BITS-1:0]   wr_period,
  output logic [COUNT_BITS-1:0]   rd_rem,
  output logic [COUNT_BITS-1:0]   rd_delay,
  output logic [COUNT_BITS-1:0]   rd_period
);
  import tmb_pkg::*;

  logic [COUNT_BITS-1:0] rem_mem    [SLOTS];
  logic [COUNT_BITS-1:0] delay_mem  [SLOTS];
  logic [COUNT_BITS-1:0] period_mem [SLOTS];
  logic [SLOTS-1:0]      valid_r;
  logic [COUNT_BITS-1:0] rd_rem_r;
  logic [COUNT_BITS-1:0] rd_delay_r;
  logic [COUNT_BITS-1:0] rd_period_r;

  always_ff @(posedge clk) begin
    if (we.rem_we) begin
      rem_mem[addr] <= wr_rem;
    end
    if (we.cfg_we) begin
      delay_mem[addr]  <= wr_delay;
      period_mem[addr] <= wr_period;
    end
    rd_rem_r    <= valid_r[addr] ? rem_mem[addr]    : '0;
    rd_delay_r  <= valid_r[addr] ? delay_mem[addr]  : '0;
    rd_period_r <= valid_r[addr] ? period_mem[addr] : '0;
  end

  // setup marks the entry as written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we.cfg_we) begin
      valid_r[addr] <= 1'b1;
    end
  end

  assign rd_rem    = rd_rem_r;
  assign rd_delay  = rd_delay_r;
  assign rd_period = rd_period_r;

endmodule

`default_nettype wire

// ===== rtl/core/tmb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmb_ctrl
// Sequencer of the timer bank: request decode, slot life states, hard and
// soft list order, tick walk and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tmb_ctrl #(
  parameter int  SLOTS      = 8,
  parameter int  COUNT_BITS = 32,
  localparam int SW         = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int PW         = SW,
  localparam int CW         = $clog2(SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tmb_pkg::tmb_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tmb_pkg::tmb_out_t       out_data,
  output logic [SW-1:0]           st_addr,
  output tmb_pkg::tmb_st_we_t     st_we,
  output logic [COUNT_BITS-1:0]   st_wr_rem,
  output logic [COUNT_BITS-1:0]   st_wr_delay,
  output logic [COUNT_BITS-1:0]   st_wr_period,
  input  logic [COUNT_BITS-1:0]   rd_rem,
  input  logic [COUNT_BITS-1:0]   rd_delay,
  input  logic [COUNT_BITS-1:0]   rd_period,
  output tmb_pkg::tmb_cu_mode_t   cu_mode,
  output logic [COUNT_BITS-1:0]   cu_a,
  output logic [COUNT_BITS-1:0]   cu_b,
  input  logic [COUNT_BITS-1:0]   cu_res,
  input  logic                    cu_fire
);
  import tmb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_EXEC,
    S_EMITQ,
    S_FIND,
    S_CALC,
    S_FLUSH
  } state_t;

  state_t          state_r, state_nxt;
  tmb_in_t         cmd_r, cmd_nxt;
  logic            out_valid_r, out_valid_nxt;
  tmb_out_t        out_data_r, out_data_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  tmb_out_t        pend_r, pend_nxt;
  logic [2:0]      life_r [SLOTS];
  logic [2:0]      life_nxt [SLOTS];
  logic            hard_r [SLOTS];
  logic            hard_nxt [SLOTS];
  logic [PW-1:0]   pos_r [SLOTS];
  logic [PW-1:0]   pos_nxt [SLOTS];
  logic [CW-1:0]   hard_cnt_r, hard_cnt_nxt;
  logic [CW-1:0]   soft_cnt_r, soft_cnt_nxt;
  logic [CW-1:0]   walk_pos_r, walk_pos_nxt;
  logic            walk_hard_r, walk_hard_nxt;
  logic [SW-1:0]   walk_slot_r, walk_slot_nxt;

  logic            slot_ok;
  logic [SW-1:0]   cmd_idx;
  logic [SW-1:0]   tgt;
  logic            can_push;
  logic            found;
  logic [SW-1:0]   found_idx;
  logic            unlink_en;
  logic            link_en;
  logic            one_shot;
  logic [SLOTS-1:0] started_hard_vec;
  logic [SLOTS-1:0] started_soft_vec;

  assign slot_ok  = (32'(cmd_r.slot) < SLOTS);
  assign cmd_idx  = SW'(cmd_r.slot);
  assign tgt      = (state_r == S_CALC) ? walk_slot_r : cmd_idx;
  assign can_push = !out_valid_r || out_ready;
  assign one_shot = (rd_period == '0);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign st_wr_rem    = cu_res;
  assign st_wr_delay  = COUNT_BITS'(cmd_r.first_delay);
  assign st_wr_period = COUNT_BITS'(cmd_r.period);

  // store address: walk lookup, timer under update, or addressed slot
  assign st_addr = (state_r == S_FIND) ? found_idx : tgt;

  // slot at the current walk position of the current list
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      started_hard_vec[s] = (life_r[s] == LIFE_STARTED) && hard_r[s];
      started_soft_vec[s] = (life_r[s] == LIFE_STARTED) && !hard_r[s];
      if ((life_r[s] == LIFE_STARTED) && (hard_r[s] == walk_hard_r) &&
          (CW'(pos_r[s]) == walk_pos_r)) begin
        found     = 1'b1;
        found_idx = SW'(s);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    life_nxt       = life_r;
    hard_nxt       = hard_r;
    pos_nxt        = pos_r;
    hard_cnt_nxt   = hard_cnt_r;
    soft_cnt_nxt   = soft_cnt_r;
    walk_pos_nxt   = walk_pos_r;
    walk_hard_nxt  = walk_hard_r;
    walk_slot_nxt  = walk_slot_r;
    st_we          = '0;
    cu_mode        = CU_STEP;
    cu_a           = rd_rem;
    cu_b           = rd_period;
    unlink_en      = 1'b0;
    link_en        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = S_DISP;
        end
      end

      // store read of the addressed slot happens here
      S_DISP: begin
        unique case (cmd_r.op) inside
          OP_TICK: begin
            walk_hard_nxt = 1'b1;
            walk_pos_nxt  = '0;
            state_nxt     = S_FIND;
          end
          OP_QUERY: begin
            state_nxt = S_EMITQ;
          end
          OP_INIT, OP_START, OP_STOP, OP_DESTROY: begin
            state_nxt = slot_ok ? S_EXEC : S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (cmd_r.op)
          OP_INIT: begin
            unlink_en       = (life_r[cmd_idx] == LIFE_STARTED);
            cu_mode         = CU_LOAD;
            cu_a            = COUNT_BITS'(cmd_r.first_delay);
            cu_b            = COUNT_BITS'(cmd_r.period);
            st_we.rem_we    = 1'b1;
            st_we.cfg_we    = 1'b1;
            hard_nxt[cmd_idx] = cmd_r.hard_type;
            life_nxt[cmd_idx] = LIFE_CREATED;
          end
          OP_START: begin
            if ((life_r[cmd_idx] == LIFE_CREATED) ||
                (life_r[cmd_idx] == LIFE_STOPPED)) begin
              cu_mode           = CU_LOAD;
              cu_a              = rd_delay;
              cu_b              = rd_period;
              st_we.rem_we      = 1'b1;
              link_en           = 1'b1;
              life_nxt[cmd_idx] = LIFE_STARTED;
            end
          end
          OP_STOP: begin
            if (life_r[cmd_idx] == LIFE_STARTED) begin
              unlink_en         = 1'b1;
              life_nxt[cmd_idx] = LIFE_STOPPED;
            end
          end
          OP_DESTROY: begin
            unlink_en         = (life_r[cmd_idx] == LIFE_STARTED);
            life_nxt[cmd_idx] = LIFE_DESTROYED;
          end
          default: begin
          end
        endcase
      end

      S_EMITQ: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{
            kind:        KIND_QUERY,
            which_slot:  cmd_r.slot,
            life_state:  slot_ok ? life_r[cmd_idx] : LIFE_UNUSED,
            info_delay:  slot_ok ? 32'(rd_delay) : 32'd0,
            info_period: slot_ok ? 32'(rd_period) : 32'd0,
            info_hard:   slot_ok ? hard_r[cmd_idx] : 1'b0,
            last:        1'b1
          };
          state_nxt = S_IDLE;
        end
      end

      S_FIND: begin
        if (found) begin
          walk_slot_nxt = found_idx;
          state_nxt     = S_CALC;
        end else if (walk_hard_r) begin
          walk_hard_nxt = 1'b0;
          walk_pos_nxt  = '0;
        end else begin
          state_nxt = pend_valid_r ? S_FLUSH : S_IDLE;
        end
      end

      // one timer step; a new fire pushes the held one out first
      S_CALC: begin
        if (!pend_valid_r || can_push) begin
          st_we.rem_we = 1'b1;
          state_nxt    = S_FIND;
          walk_pos_nxt = walk_pos_r + CW'(1);
          if (cu_fire) begin
            if (one_shot) begin
              unlink_en             = 1'b1;
              life_nxt[walk_slot_r] = LIFE_STOPPED;
              walk_pos_nxt          = walk_pos_r;
            end
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pend_r;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = '{
              kind:        KIND_FIRE,
              which_slot:  3'(walk_slot_r),
              life_state:  one_shot ? LIFE_STOPPED : LIFE_STARTED,
              info_delay:  32'd0,
              info_period: 32'd0,
              info_hard:   1'b0,
              last:        1'b0
            };
          end
        end
      end

      S_FLUSH: begin
        if (can_push) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_valid_nxt    = 1'b0;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // list maintenance: close the gap behind a leaving timer
    if (unlink_en) begin
      for (int t = 0; t < SLOTS; t++) begin
        if ((SW'(t) != tgt) && (life_r[t] == LIFE_STARTED) &&
            (hard_r[t] == hard_r[tgt]) && (pos_r[t] > pos_r[tgt])) begin
          pos_nxt[t] = pos_r[t] - PW'(1);
        end
      end
      pos_nxt[tgt] = '0;
      if (hard_r[tgt]) begin
        hard_cnt_nxt = hard_cnt_r - CW'(1);
      end else begin
        soft_cnt_nxt = soft_cnt_r - CW'(1);
      end
    end

    // hard timers enter at the head, soft ones at the tail
    if (link_en) begin
      if (hard_r[tgt]) begin
        for (int t = 0; t < SLOTS; t++) begin
          if (started_hard_vec[t]) begin
            pos_nxt[t] = pos_r[t] + PW'(1);
          end
        end
        pos_nxt[tgt] = '0;
        hard_cnt_nxt = hard_cnt_r + CW'(1);
      end else begin
        pos_nxt[tgt] = PW'(soft_cnt_r);
        soft_cnt_nxt = soft_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    out_data_r  <= out_data_nxt;
    pend_r      <= pend_nxt;
    walk_slot_r <= walk_slot_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      hard_cnt_r   <= '0;
      soft_cnt_r   <= '0;
      walk_pos_r   <= '0;
      walk_hard_r  <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        life_r[s] <= LIFE_UNUSED;
        hard_r[s] <= 1'b0;
        pos_r[s]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      hard_cnt_r   <= hard_cnt_nxt;
      soft_cnt_r   <= soft_cnt_nxt;
      walk_pos_r   <= walk_pos_nxt;
      walk_hard_r  <= walk_hard_nxt;
      life_r       <= life_nxt;
      hard_r       <= hard_nxt;
      pos_r        <= pos_nxt;
    end
  end

  `TMB_ASSERT(a_hard_cnt, hard_cnt_r == CW'($countones(started_hard_vec)), "hard list count off")
  `TMB_ASSERT(a_soft_cnt, soft_cnt_r == CW'($countones(started_soft_vec)), "soft list count off")
  `TMB_ASSERT(a_walk_pos, (state_r == S_FIND) |-> (walk_pos_r <= (walk_hard_r ? hard_cnt_r : soft_cnt_r)), "walk past list end")
  `TMB_NEVER(a_pend_idle, pend_valid_r && (state_r != S_FIND) && (state_r != S_CALC) && (state_r != S_FLUSH), "held fire outside walk")

endmodule

`default_nettype wire

// ===== rtl/core/periodic_timer_bank_unit.sv =====
// Results: a tick's last result follows the walk of all started timers; any
//   result can wait on a full output register.
// Requests: one at a time; the next is taken once the block is idle.
// Walk: each timer takes a find state and a calc state, as the single-port
//   count store feeds the shared count unit; a full output can hold it.
// Sync reset: all slots unused, no sweep.
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit
// Bank of hard/soft periodic and one-shot timers with init, start, stop,
// destroy, query and tick requests; fire events and query answers out.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank_unit #(
  parameter int SLOTS      = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tmb_pkg::tmb_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tmb_pkg::tmb_out_t  out_data
);
  import tmb_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // store port, driven by the sequencer
  logic [SW-1:0]         st_addr;
  tmb_st_we_t            st_we;
  logic [COUNT_BITS-1:0] st_wr_rem;
  logic [COUNT_BITS-1:0] st_wr_delay;
  logic [COUNT_BITS-1:0] st_wr_period;
  logic [COUNT_BITS-1:0] rd_rem;
  logic [COUNT_BITS-1:0] rd_delay;
  logic [COUNT_BITS-1:0] rd_period;

  // shared count unit operands
  tmb_cu_mode_t          cu_mode;
  logic [COUNT_BITS-1:0] cu_a;
  logic [COUNT_BITS-1:0] cu_b;
  logic [COUNT_BITS-1:0] cu_res;
  logic                  cu_fire;

  // Sequencer: decodes each request, keeps life states and list order,
  // walks hard then soft list on a tick and owns the output register.
  // One fire result is held back so the final one can carry last.
  tmb_ctrl #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .st_addr      (st_addr),
    .st_we        (st_we),
    .st_wr_rem    (st_wr_rem),
    .st_wr_delay  (st_wr_delay),
    .st_wr_period (st_wr_period),
    .rd_rem       (rd_rem),
    .rd_delay     (rd_delay),
    .rd_period    (rd_period),
    .cu_mode      (cu_mode),
    .cu_a         (cu_a),
    .cu_b         (cu_b),
    .cu_res       (cu_res),
    .cu_fire      (cu_fire)
  );

  // Count/delay/period storage, registered read: the sequencer addresses
  // a slot in the cycle before it uses the data.
  tmb_store #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .addr      (st_addr),
    .we        (st_we),
    .wr_rem    (st_wr_rem),
    .wr_delay  (st_wr_delay),
    .wr_period (st_wr_period),
    .rd_rem    (rd_rem),
    .rd_delay  (rd_delay),
    .rd_period (rd_period)
  );

  // One decrement/compare/reload unit shared by setup, start and every
  // timer step of the walk.
  tmb_count_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .mode (cu_mode),
    .a    (cu_a),
    .b    (cu_b),
    .res  (cu_res),
    .fire (cu_fire)
  );

endmodule

`default_nettype wire
